// ===== design/hcar_pkg.sv =====
// Shared types, codes and register-file access functions for the handheld CPU ALU.
`timescale 1ns / 1ps

package hcar_pkg;

    localparam int OP_W     = 5;
    localparam int TGT_W    = 4;
    localparam int BIDX_W   = 3;
    localparam int WIDE_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int FLAG_W   = 4;
    localparam int NUM_REGS = 8;

    // Eight 8-bit registers, indexed A,B,C,D,E,F,H,L.
    typedef logic [NUM_REGS-1:0][BYTE_W-1:0] rf_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 5'd0,
        OP_ADD16 = 5'd1,
        OP_ADC   = 5'd2,
        OP_SUB   = 5'd3,
        OP_SBC   = 5'd4,
        OP_AND   = 5'd5,
        OP_OR    = 5'd6,
        OP_XOR   = 5'd7,
        OP_CP    = 5'd8,
        OP_INC   = 5'd9,
        OP_DEC   = 5'd10,
        OP_CCF   = 5'd11,
        OP_SCF   = 5'd12,
        OP_RRA   = 5'd13,
        OP_RLA   = 5'd14,
        OP_RRCA  = 5'd15,
        OP_RLCA  = 5'd16,
        OP_CPL   = 5'd17,
        OP_BIT   = 5'd18,
        OP_RES   = 5'd19,
        OP_SET   = 5'd20,
        OP_SRL   = 5'd21,
        OP_RR    = 5'd22,
        OP_RL    = 5'd23,
        OP_RRC   = 5'd24,
        OP_RLC   = 5'd25,
        OP_SRA   = 5'd26,
        OP_SLA   = 5'd27,
        OP_SWAP  = 5'd28,
        OP_LOAD  = 5'd29
    } op_t;

    localparam logic [2:0] REG_A = 3'd0;
    localparam logic [2:0] REG_B = 3'd1;
    localparam logic [2:0] REG_C = 3'd2;
    localparam logic [2:0] REG_D = 3'd3;
    localparam logic [2:0] REG_E = 3'd4;
    localparam logic [2:0] REG_F = 3'd5;
    localparam logic [2:0] REG_H = 3'd6;
    localparam logic [2:0] REG_L = 3'd7;

    localparam logic [TGT_W-1:0] TGT_A  = 4'd0;
    localparam logic [TGT_W-1:0] TGT_F  = 4'd5;
    localparam logic [TGT_W-1:0] TGT_BC = 4'd8;
    localparam logic [TGT_W-1:0] TGT_DE = 4'd9;
    localparam logic [TGT_W-1:0] TGT_HL = 4'd10;

    localparam logic [BYTE_W-1:0] FLAG_MASK = 8'hF0;

    function automatic logic is_pair(logic [TGT_W-1:0] t);
        return (t == TGT_BC) || (t == TGT_DE) || (t == TGT_HL);
    endfunction

    function automatic logic [2:0] pair_lo(logic [TGT_W-1:0] t);
        return (t == TGT_BC) ? REG_C : (t == TGT_DE) ? REG_E : REG_L;
    endfunction

    function automatic logic [2:0] pair_hi(logic [TGT_W-1:0] t);
        return (t == TGT_BC) ? REG_B : (t == TGT_DE) ? REG_D : REG_H;
    endfunction

    // Byte read: a pair stands for its low register, unused codes read zero.
    function automatic logic [BYTE_W-1:0] rd8(rf_t rf, logic [TGT_W-1:0] t);
        if (!t[3])
        begin
            return rf[t[2:0]];
        end
        else if (is_pair(t))
        begin
            return rf[pair_lo(t)];
        end
        return '0;
    endfunction

    function automatic logic [WIDE_W-1:0] rd16(rf_t rf, logic [TGT_W-1:0] t);
        if (!t[3])
        begin
            return {8'h00, rf[t[2:0]]};
        end
        else if (is_pair(t))
        begin
            return {rf[pair_hi(t)], rf[pair_lo(t)]};
        end
        return '0;
    endfunction

    // Byte write: F keeps only its upper nibble, unused codes are ignored.
    function automatic rf_t wr8(rf_t rf, logic [TGT_W-1:0] t, logic [BYTE_W-1:0] v);
        rf_t r;
        r = rf;
        if (!t[3])
        begin
            r[t[2:0]] = (t == TGT_F) ? (v & FLAG_MASK) : v;
        end
        else if (is_pair(t))
        begin
            r[pair_lo(t)] = v;
        end
        return r;
    endfunction

    function automatic rf_t wr16(rf_t rf, logic [TGT_W-1:0] t, logic [WIDE_W-1:0] v);
        rf_t r;
        r = rf;
        if (!t[3])
        begin
            r = wr8(rf, t, v[7:0]);
        end
        else if (is_pair(t))
        begin
            r[pair_hi(t)] = v[15:8];
            r[pair_lo(t)] = v[7:0];
        end
        return r;
    endfunction

endpackage

// ===== design/hcar_cmd_if.sv =====
// Command channel interface: one instruction word per handshake.
`timescale 1ns / 1ps

interface hcar_cmd_if
    import hcar_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [TGT_W-1:0]  target;
    logic [BIDX_W-1:0] bit_pos;
    logic [WIDE_W-1:0] load_value;

    modport source (output valid, output op, output target, output bit_pos,
                    output load_value, input ready);
    modport sink   (input valid, input op, input target, input bit_pos,
                    input load_value, output ready);
endinterface

// ===== design/hcar_rsp_if.sv =====
// Response channel interface: result value and new flags per handshake.
`timescale 1ns / 1ps

interface hcar_rsp_if
    import hcar_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WIDE_W-1:0] result;
    logic [FLAG_W-1:0] flags;

    modport source (output valid, output result, output flags, input ready);
    modport sink   (input valid, input result, input flags, output ready);
endinterface

// ===== design/handheld_cpu_alu_regfile.sv =====
// Top level of the handheld CPU ALU with its register file and word handshakes.
`timescale 1ns / 1ps
// A word accepted on cmd waits in the command stage, is executed into the result
// register when that register is empty or being drained, and is then offered on rsp.
// Throughput: one word per cycle unless rsp stalls; the single execute pass
// updates the register file in the same edge that loads the result register,
// so the next word sees the new state.
// Reset clears the register file to zero and empties the command and result stages.

module handheld_cpu_alu_regfile
    import hcar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hcar_cmd_if.sink   cmd,
    hcar_rsp_if.source rsp
);

    // Command stage: holds one instruction word until the execute pass takes it.
    logic              cmd_vld_reg;
    logic              cmd_vld_next;
    logic [OP_W-1:0]   op_reg;
    logic [TGT_W-1:0]  tgt_reg;
    logic [BIDX_W-1:0] bidx_reg;
    logic [WIDE_W-1:0] lval_reg;

    // Result stage: holds the finished word until the consumer takes it.
    logic              rsp_vld_reg;
    logic              rsp_vld_next;
    logic [WIDE_W-1:0] result_reg;
    logic [FLAG_W-1:0] flags_reg;

    logic              advance;
    logic              cmd_take;
    rf_t               rf;
    rf_t               rf_next;
    logic [WIDE_W-1:0] exec_result;
    logic [FLAG_W-1:0] exec_flags;

    // The held word executes when the result register is empty or being drained.
    assign advance   = cmd_vld_reg && (!rsp_vld_reg || rsp.ready);
    assign cmd.ready = !cmd_vld_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    assign cmd_vld_next = cmd_take || (cmd_vld_reg && !advance);
    assign rsp_vld_next = advance || (rsp_vld_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            cmd_vld_reg <= cmd_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg   <= cmd.op;
            tgt_reg  <= cmd.target;
            bidx_reg <= cmd.bit_pos;
            lval_reg <= cmd.load_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= exec_result;
            flags_reg  <= exec_flags;
        end
    end

    hcar_exec u_exec (
        .op         (op_reg),
        .target     (tgt_reg),
        .bit_pos    (bidx_reg),
        .load_value (lval_reg),
        .rf         (rf),
        .rf_next    (rf_next),
        .result     (exec_result),
        .flags      (exec_flags)
    );

    // The register file commits exactly when the result register loads.
    hcar_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (advance),
        .rf_next (rf_next),
        .rf      (rf)
    );

    assign rsp.valid  = rsp_vld_reg;
    assign rsp.result = result_reg;
    assign rsp.flags  = flags_reg;

endmodule

// ===== design/hcar_regfile.sv =====
// Architectural register file A,B,C,D,E,F,H,L with whole-file update.
`timescale 1ns / 1ps

module hcar_regfile
    import hcar_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic we,
    input  rf_t  rf_next,
    output rf_t  rf
);

    rf_t rf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_reg <= '0;
        end
        else if (we)
        begin
            rf_reg <= rf_next;
        end
    end

    assign rf = rf_reg;

endmodule

// ===== design/hcar_exec.sv =====
// Single-pass execute logic: decodes one instruction and forms the next register file.
`timescale 1ns / 1ps

module hcar_exec
    import hcar_pkg::*;
(
    input  logic [OP_W-1:0]   op,
    input  logic [TGT_W-1:0]  target,
    input  logic [BIDX_W-1:0] bit_pos,
    input  logic [WIDE_W-1:0] load_value,
    input  rf_t               rf,
    output rf_t               rf_next,
    output logic [WIDE_W-1:0] result,
    output logic [FLAG_W-1:0] flags
);

    op_t               op_c;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] f;
    logic [BYTE_W-1:0] v;
    logic              zin;
    logic              cin;
    logic              cy;
    logic [8:0]        sum9;
    logic [4:0]        hsum5;
    logic [8:0]        diff9;
    logic [4:0]        hdiff5;
    logic [WIDE_W-1:0] hl;
    logic [WIDE_W-1:0] w;
    logic [16:0]       sum17;
    logic [12:0]       hsum13;
    logic [WIDE_W-1:0] pair_val;
    logic [BYTE_W-1:0] logic_r;
    logic [BYTE_W-1:0] bit_mask;
    logic [BYTE_W-1:0] sh_r;
    logic              sh_c;

    logic              fl_we;
    logic [FLAG_W-1:0] fl_val;
    logic              w8_we;
    logic [TGT_W-1:0]  w8_tgt;
    logic [BYTE_W-1:0] w8_val;
    logic              w16_we;
    logic [TGT_W-1:0]  w16_tgt;
    logic [WIDE_W-1:0] w16_val;
    logic [TGT_W-1:0]  show_tgt;
    logic              show_wide;
    logic              show_fix;
    logic [WIDE_W-1:0] shown_fix;
    rf_t               rf_fl;
    rf_t               rf_w8;

    assign op_c = op_t'(op);
    assign a    = rf[REG_A];
    assign f    = rf[REG_F];
    assign zin  = f[7];
    assign cin  = f[4];
    assign v    = rd8(rf, target);

    // Carry into adc and sbc only.
    assign cy = ((op_c == OP_ADC) || (op_c == OP_SBC)) ? cin : 1'b0;

    assign sum9   = {1'b0, a} + {1'b0, v} + {8'h00, cy};
    assign hsum5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, cy};
    assign diff9  = {1'b0, a} - {1'b0, v} - {8'h00, cy};
    assign hdiff5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, cy};

    assign hl     = rd16(rf, TGT_HL);
    assign w      = rd16(rf, target);
    assign sum17  = {1'b0, hl} + {1'b0, w};
    assign hsum13 = {1'b0, hl[11:0]} + {1'b0, w[11:0]};

    assign pair_val = (op_c == OP_INC) ? (w + 16'd1) : (w - 16'd1);
    assign bit_mask = 8'(1) << bit_pos;

    always_comb
    begin
        unique case (op_c)
            OP_AND:  logic_r = a & v;
            OP_OR:   logic_r = a | v;
            default: logic_r = a ^ v;
        endcase
    end

    // CB-prefix rotates, shifts and nibble swap on the operand byte.
    always_comb
    begin
        unique case (op_c)
            OP_SRL:
            begin
                sh_r = {1'b0, v[7:1]};
                sh_c = v[0];
            end
            OP_RR:
            begin
                sh_r = {cin, v[7:1]};
                sh_c = v[0];
            end
            OP_RL:
            begin
                sh_r = {v[6:0], cin};
                sh_c = v[7];
            end
            OP_RRC:
            begin
                sh_r = {v[0], v[7:1]};
                sh_c = v[0];
            end
            OP_RLC:
            begin
                sh_r = {v[6:0], v[7]};
                sh_c = v[7];
            end
            OP_SRA:
            begin
                sh_r = {v[7], v[7:1]};
                sh_c = v[0];
            end
            OP_SLA:
            begin
                sh_r = {v[6:0], 1'b0};
                sh_c = v[7];
            end
            default:
            begin
                sh_r = {v[3:0], v[7:4]};
                sh_c = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        fl_we     = 1'b0;
        fl_val    = f[7:4];
        w8_we     = 1'b0;
        w8_tgt    = target;
        w8_val    = '0;
        w16_we    = 1'b0;
        w16_tgt   = target;
        w16_val   = load_value;
        show_tgt  = target;
        show_wide = 1'b0;
        show_fix  = 1'b0;
        shown_fix = '0;

        unique case (op_c)
            OP_ADD, OP_ADC:
            begin
                fl_we    = 1'b1;
                fl_val   = {sum9[7:0] == 8'h00, 1'b0, hsum5[4], sum9[8]};
                w8_we    = 1'b1;
                w8_tgt   = TGT_A;
                w8_val   = sum9[7:0];
                show_tgt = TGT_A;
            end
            OP_ADD16:
            begin
                fl_we     = 1'b1;
                fl_val    = {zin, 1'b0, hsum13[12], sum17[16]};
                w16_we    = 1'b1;
                w16_tgt   = TGT_HL;
                w16_val   = sum17[15:0];
                show_tgt  = TGT_HL;
                show_wide = 1'b1;
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                fl_we  = 1'b1;
                fl_val = {diff9[7:0] == 8'h00, 1'b1, hdiff5[4], diff9[8]};
                if (op_c == OP_CP)
                begin
                    show_fix  = 1'b1;
                    shown_fix = {8'h00, v};
                end
                else
                begin
                    w8_we    = 1'b1;
                    w8_tgt   = TGT_A;
                    w8_val   = diff9[7:0];
                    show_tgt = TGT_A;
                end
            end
            OP_AND, OP_OR, OP_XOR:
            begin
                fl_we    = 1'b1;
                fl_val   = {logic_r == 8'h00, 1'b0, op_c == OP_AND, 1'b0};
                w8_we    = 1'b1;
                w8_tgt   = TGT_A;
                w8_val   = logic_r;
                show_tgt = TGT_A;
            end
            OP_INC, OP_DEC:
            begin
                if (is_pair(target))
                begin
                    // Pair increment and decrement leave the flags alone.
                    w16_we    = 1'b1;
                    w16_val   = pair_val;
                    show_wide = 1'b1;
                end
                else
                begin
                    fl_we = 1'b1;
                    w8_we = 1'b1;
                    if (op_c == OP_INC)
                    begin
                        w8_val = v + 8'd1;
                        fl_val = {v == 8'hFF, 1'b0, v[3:0] == 4'hF, cin};
                    end
                    else
                    begin
                        w8_val = v - 8'd1;
                        fl_val = {v == 8'h01, 1'b1, v[3:0] == 4'h0, cin};
                    end
                end
            end
            OP_CCF, OP_SCF:
            begin
                fl_we     = 1'b1;
                fl_val    = {zin, 1'b0, 1'b0, (op_c == OP_CCF) ? ~cin : 1'b1};
                show_fix  = 1'b1;
                shown_fix = {8'h00, a};
            end
            OP_RRA, OP_RLA, OP_RRCA, OP_RLCA:
            begin
                fl_we    = 1'b1;
                w8_we    = 1'b1;
                w8_tgt   = TGT_A;
                show_tgt = TGT_A;
                if (op_c == OP_RRA)
                begin
                    w8_val = {cin, a[7:1]};
                end
                else if (op_c == OP_RLA)
                begin
                    w8_val = {a[6:0], cin};
                end
                else if (op_c == OP_RRCA)
                begin
                    w8_val = {a[0], a[7:1]};
                end
                else
                begin
                    w8_val = {a[6:0], a[7]};
                end
                fl_val = {3'b000,
                          ((op_c == OP_RRA) || (op_c == OP_RRCA)) ? a[0] : a[7]};
            end
            OP_CPL:
            begin
                fl_we    = 1'b1;
                fl_val   = {zin, 1'b1, 1'b1, cin};
                w8_we    = 1'b1;
                w8_tgt   = TGT_A;
                w8_val   = ~a;
                show_tgt = TGT_A;
            end
            OP_BIT:
            begin
                fl_we     = 1'b1;
                fl_val    = {~v[bit_pos], 1'b0, 1'b1, cin};
                show_fix  = 1'b1;
                shown_fix = {8'h00, v};
            end
            OP_RES:
            begin
                w8_we  = 1'b1;
                w8_val = v & ~bit_mask;
            end
            OP_SET:
            begin
                w8_we  = 1'b1;
                w8_val = v | bit_mask;
            end
            OP_SRL, OP_RR, OP_RL, OP_RRC, OP_RLC, OP_SRA, OP_SLA, OP_SWAP:
            begin
                fl_we  = 1'b1;
                fl_val = {sh_r == 8'h00, 1'b0, 1'b0, sh_c};
                w8_we  = 1'b1;
                w8_val = sh_r;
            end
            OP_LOAD:
            begin
                if (is_pair(target))
                begin
                    w16_we    = 1'b1;
                    show_wide = 1'b1;
                end
                else
                begin
                    w8_we  = 1'b1;
                    w8_val = load_value[7:0];
                end
            end
            default:
            begin
                // Undefined opcodes change nothing and return zero.
                show_fix  = 1'b1;
                shown_fix = '0;
            end
        endcase
    end

    // The flag update lands first, so a result written to F wins.
    always_comb
    begin
        rf_fl = rf;
        if (fl_we)
        begin
            rf_fl[REG_F] = {fl_val, 4'h0};
        end
        rf_w8 = w8_we ? wr8(rf_fl, w8_tgt, w8_val) : rf_fl;
        rf_next = w16_we ? wr16(rf_w8, w16_tgt, w16_val) : rf_w8;
    end

    assign result = show_fix  ? shown_fix :
                    show_wide ? rd16(rf_next, show_tgt) :
                                {8'h00, rd8(rf_next, show_tgt)};
    assign flags  = rf_next[REG_F][7:4];

endmodule

// ===== design/hcar_checker.sv =====
// Port-level checker for the handheld CPU ALU and its bind to the top level.
`timescale 1ns / 1ps

module hcar_checker
    import hcar_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [WIDE_W-1:0] rsp_result,
    input logic [FLAG_W-1:0] rsp_flags
);

    // A stalled result word stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word withdrawn while stalled");

    // A stalled result word keeps its payload.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_result) && $stable(rsp_flags))
        else $error("result payload changed while stalled");

    // A fresh result needs a command word taken before it, passed through the command and result stages.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("result word appeared without a matching command");

    // With the output stalled, one more word fills the command stage.
    a_cmd_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready && cmd_valid && cmd_ready |=> !cmd_ready || rsp_ready)
        else $error("command stage accepted beyond its depth");

endmodule

bind handheld_cpu_alu_regfile hcar_checker u_hcar_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_result (rsp.result),
    .rsp_flags  (rsp.flags)
);
